### hw/rtl/lje_pkg.sv
// Shared types, codes and constants of the lepton-plus-jets event selector.
package lje_pkg;

  // Object kinds carried on s_axis_tuser
  localparam logic [1:0] OP_ELE = 2'd0;
  localparam logic [1:0] OP_MU  = 2'd1;
  localparam logic [1:0] OP_JET = 2'd2;
  localparam logic [1:0] OP_MET = 2'd3;

  // Reject reasons
  localparam logic [2:0] RSN_PASS = 3'd0;
  localparam logic [2:0] RSN_LEP  = 3'd1;
  localparam logic [2:0] RSN_JET  = 3'd2;
  localparam logic [2:0] RSN_TAG  = 3'd3;
  localparam logic [2:0] RSN_MT   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] REG_ELE_TIGHT = 3'd0;
  localparam logic [2:0] REG_ELE_LOOSE = 3'd1;
  localparam logic [2:0] REG_MU_TIGHT  = 3'd2;
  localparam logic [2:0] REG_MU_LOOSE  = 3'd3;
  localparam logic [2:0] REG_MT_THR    = 3'd4;
  localparam logic [2:0] REG_ELE_ETA   = 3'd5;
  localparam logic [2:0] REG_MU_ETA    = 3'd6;

  // Odd Taylor coefficients of sin(pi*x), Q30
  localparam logic [32:0] SIN_C1 = 33'd3373259426;
  localparam logic [32:0] SIN_C3 = 33'd5548789346;
  localparam logic [32:0] SIN_C5 = 33'd2738217788;
  localparam logic [32:0] SIN_C7 = 33'd643455389;
  localparam logic [32:0] SIN_C9 = 33'd88203474;

  localparam int unsigned SQRT_STEPS = 24;
  localparam logic [4:0]  SQRT_LAST  = 5'(SQRT_STEPS - 1);
  localparam logic [1:0]  HORN_LAST  = 2'd3;

  localparam logic [16:0] MT_MAX   = 17'h1FFFF;
  localparam logic [30:0] SIN_ONE  = 31'h4000_0000;

  typedef struct packed {
    logic       take;    // input beat accepted
    logic       prep;    // form pt*met and the folded angle
    logic       horner;  // one Horner step of the sine polynomial
    logic [1:0] hsel;    // which coefficient this step subtracts from
    logic       sfin;    // finish sine, load root iteration
    logic       sqrt;    // one root digit
    logic       mtmul;   // root times sine
    logic       fin;     // round, compare and load result
  } lje_cmd_t;

  typedef struct packed {
    logic pass;          // event counts allow the mass check
    logic out_valid;     // result beat held on the master side
  } lje_status_t;

endpackage

### hw/rtl/lje_ctrl.sv
// Sequencer of the event selector: steps the closing-item computation.
module lje_ctrl import lje_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  input  logic [1:0]  s_op_i,
  input  logic        m_ready_i,
  input  lje_status_t status_i,
  output logic        s_ready_o,
  output lje_cmd_t    cmd_o
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PREP  = 3'd1;
  localparam logic [2:0] ST_HORN  = 3'd2;
  localparam logic [2:0] ST_SFIN  = 3'd3;
  localparam logic [2:0] ST_SQRT  = 3'd4;
  localparam logic [2:0] ST_MTMUL = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  logic [2:0] state_q, state_d;
  logic [4:0] cnt_q, cnt_d;
  logic       take;

  assign s_ready_o = (state_q == ST_IDLE) && (!status_i.out_valid || m_ready_i);
  assign take      = s_valid_i && s_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.take = take;
    cmd_o.hsel = cnt_q[1:0];
    unique case (state_q)
      ST_IDLE: begin
        if (take && s_op_i == OP_MET && status_i.pass) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd_o.prep = 1'b1;
        cnt_d      = '0;
        state_d    = ST_HORN;
      end
      ST_HORN: begin
        cmd_o.horner = 1'b1;
        cnt_d        = cnt_q + 5'd1;
        if (cnt_q[1:0] == HORN_LAST) begin
          state_d = ST_SFIN;
        end
      end
      ST_SFIN: begin
        cmd_o.sfin = 1'b1;
        cnt_d      = '0;
        state_d    = ST_SQRT;
      end
      ST_SQRT: begin
        cmd_o.sqrt = 1'b1;
        cnt_d      = cnt_q + 5'd1;
        if (cnt_q == SQRT_LAST) begin
          state_d = ST_MTMUL;
        end
      end
      ST_MTMUL: begin
        cmd_o.mtmul = 1'b1;
        state_d     = ST_FIN;
      end
      ST_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

### hw/rtl/lje_datapath.sv
// Datapath of the event selector: cuts, counters, mass arithmetic, result register.
module lje_datapath import lje_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  lje_cmd_t    cmd_i,
  input  logic [1:0]  op_i,
  input  logic [15:0] pt_i,
  input  logic [9:0]  eta_i,
  input  logic [15:0] phi_i,
  input  logic        btag_i,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        m_ready_i,
  output lje_status_t status_o,
  output logic [63:0] m_data_o
);

  // Configuration
  logic [15:0] ele_tight_q, ele_loose_q, mu_tight_q, mu_loose_q;
  logic [16:0] mt_thr_q;
  logic [8:0]  ele_eta_q, mu_eta_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ele_tight_q <= 16'd480;
      ele_loose_q <= 16'd160;
      mu_tight_q  <= 16'd480;
      mu_loose_q  <= 16'd160;
      mt_thr_q    <= 17'd0;
      ele_eta_q   <= 9'd250;
      mu_eta_q    <= 9'd240;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ELE_TIGHT: ele_tight_q <= cfg_wdata_i[15:0];
        REG_ELE_LOOSE: ele_loose_q <= cfg_wdata_i[15:0];
        REG_MU_TIGHT:  mu_tight_q  <= cfg_wdata_i[15:0];
        REG_MU_LOOSE:  mu_loose_q  <= cfg_wdata_i[15:0];
        REG_MT_THR:    mt_thr_q    <= cfg_wdata_i;
        REG_ELE_ETA:   ele_eta_q   <= cfg_wdata_i[8:0];
        REG_MU_ETA:    mu_eta_q    <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // Event state
  logic [1:0]  tight_q, loose_q, tag_q;
  logic [2:0]  jet_q;
  logic [15:0] kpt_q, kphi_q;
  logic [9:0]  keta_q;

  logic [9:0]  aeta;
  logic [15:0] loose_cut, tight_cut;
  logic [8:0]  eta_lim;
  logic        is_lep, is_loose, is_tight, is_close, fail_now, clear_evt;
  logic [2:0]  reason_cnt;

  assign aeta      = eta_i[9] ? 10'(~eta_i + 10'd1) : eta_i;
  assign loose_cut = (op_i == OP_MU) ? mu_loose_q : ele_loose_q;
  assign tight_cut = (op_i == OP_MU) ? mu_tight_q : ele_tight_q;
  assign eta_lim   = (op_i == OP_MU) ? mu_eta_q : ele_eta_q;
  assign is_lep    = (op_i == OP_ELE) || (op_i == OP_MU);
  assign is_loose  = (pt_i >= loose_cut) && (aeta <= {1'b0, eta_lim});
  assign is_tight  = is_loose && (pt_i > tight_cut);
  assign is_close  = cmd_i.take && (op_i == OP_MET);

  always_comb begin
    priority if (tight_q != 2'd1 || loose_q != 2'd1) begin
      reason_cnt = RSN_LEP;
    end else if (jet_q < 3'd4) begin
      reason_cnt = RSN_JET;
    end else if (tag_q < 2'd2) begin
      reason_cnt = RSN_TAG;
    end else begin
      reason_cnt = RSN_PASS;
    end
  end

  assign status_o.pass = (reason_cnt == RSN_PASS);
  assign fail_now      = is_close && !status_o.pass;
  assign clear_evt     = fail_now || cmd_i.fin;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tight_q <= '0;
      loose_q <= '0;
      jet_q   <= '0;
      tag_q   <= '0;
      kpt_q   <= '0;
      keta_q  <= '0;
      kphi_q  <= '0;
    end else if (clear_evt) begin
      tight_q <= '0;
      loose_q <= '0;
      jet_q   <= '0;
      tag_q   <= '0;
      kpt_q   <= '0;
      keta_q  <= '0;
      kphi_q  <= '0;
    end else if (cmd_i.take) begin
      if (is_lep && is_loose) begin
        if (loose_q != 2'd3) loose_q <= loose_q + 2'd1;
        if (is_tight) begin
          if (tight_q != 2'd3) tight_q <= tight_q + 2'd1;
          kpt_q  <= pt_i;
          keta_q <= eta_i;
          kphi_q <= phi_i;
        end
      end
      if (op_i == OP_JET) begin
        if (jet_q != 3'd4) jet_q <= jet_q + 3'd1;
        if (btag_i && tag_q != 2'd2) tag_q <= tag_q + 2'd1;
      end
    end
  end

  // Transverse mass
  logic [15:0] met_q, mphi_q, dp_q, dphi, dfold;
  logic [31:0] rad_prod_q, u_q;
  logic [32:0] t_q, coef, t_d;
  logic [64:0] horn_prod;
  logic [48:0] sin_prod;
  logic [32:0] sin_raw;
  logic [30:0] s_q;
  logic [47:0] rad_q;
  logic [25:0] rem_q;
  logic [23:0] root_q;
  logic [27:0] rem_sh, trial;
  logic [54:0] mtp_q;
  logic [55:0] mt_sum;
  logic [18:0] mt_wide;
  logic [16:0] mt_val;
  logic [2:0]  reason_fin;

  assign dphi  = kphi_q - mphi_q;
  assign dfold = (dphi > 16'h8000) ? 16'(~dphi + 16'd1) : dphi;

  always_comb begin
    unique case (cmd_i.hsel)
      2'd0:    coef = SIN_C7;
      2'd1:    coef = SIN_C5;
      2'd2:    coef = SIN_C3;
      default: coef = SIN_C1;
    endcase
  end

  assign horn_prod = {1'b0, u_q} * t_q;
  assign t_d       = coef - horn_prod[64:32];
  assign sin_prod  = dp_q * t_q;
  assign sin_raw   = sin_prod[48:16];
  assign rem_sh    = {rem_q, rad_q[47:46]};
  assign trial     = {2'b00, root_q, 2'b01};
  assign mt_sum    = {1'b0, mtp_q} + (56'd1 << 36);
  assign mt_wide   = mt_sum[55:37];
  assign mt_val    = (mt_wide > {2'b00, MT_MAX}) ? MT_MAX : mt_wide[16:0];
  assign reason_fin = (mt_val < mt_thr_q) ? RSN_MT : RSN_PASS;

  always_ff @(posedge clk_i) begin
    if (is_close) begin
      met_q  <= pt_i;
      mphi_q <= phi_i;
    end
    if (cmd_i.prep) begin
      rad_prod_q <= kpt_q * met_q;
      dp_q       <= dfold;
      u_q        <= dfold * dfold;
      t_q        <= SIN_C9;
    end
    if (cmd_i.horner) begin
      t_q <= t_d;
    end
    if (cmd_i.sfin) begin
      s_q    <= (sin_raw > {2'b00, SIN_ONE}) ? SIN_ONE : sin_raw[30:0];
      rad_q  <= {rad_prod_q, 16'd0};
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.sqrt) begin
      rad_q <= {rad_q[45:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= 26'(rem_sh - trial);
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[25:0];
        root_q <= {root_q[22:0], 1'b0};
      end
    end
    if (cmd_i.mtmul) begin
      mtp_q <= root_q * s_q;
    end
  end

  // Result register
  logic        out_valid_q;
  logic [63:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (clear_evt) begin
      out_valid_q <= 1'b1;
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fail_now) begin
      out_data_q <= {1'b0, kphi_q, keta_q, kpt_q, 17'd0, reason_cnt, 1'b0};
    end else if (cmd_i.fin) begin
      out_data_q <= {1'b0, kphi_q, keta_q, kpt_q, mt_val, reason_fin,
                     reason_fin == RSN_PASS};
    end
  end

  assign status_o.out_valid = out_valid_q;
  assign m_data_o           = out_data_q;

endmodule

### hw/rtl/lepton_jets_event_selector_core.sv
// Top level of the lepton-plus-jets event selector.
//
// Input stream: one object per beat. s_axis_tuser carries the kind (electron,
// muon, jet, missing momentum); the missing-momentum beat closes the event.
// Object beats only update cut decisions, saturating counters and the kept
// tight lepton. A closing beat whose counts fail is answered in the next cycle;
// one whose counts pass runs the mass computation: a product step, four
// Horner steps of the sine polynomial on one shared multiplier, one sine
// finish, 24 root digits (one per cycle) and a final multiply and round.
// Object beats follow one per cycle while the selector is idle and the output
// slot is free or draining; the root iteration sets the closing beat's cost.
// Output stream: one beat per closing item, held in a register until taken;
// while it waits, no further input beat is accepted until the slot drains.
// A stalled receiver holds the beat stable.
// Reset restores the register defaults and clears all event counters;
// configuration writes are taken at any edge with cfg_we_i high and must be
// made while no event is being closed.
module lepton_jets_event_selector_core import lje_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,  // pt[15:0], eta[25:16], phi[41:26], btag[42], zero
  input  logic [1:0]  s_axis_tuser,  // op[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,  // accepted[0], reject_reason[3:1],
                                     // transverse_mass[20:4], lepton_pt[36:21],
                                     // lepton_eta[46:37], lepton_phi[62:47], zero
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i
);

  lje_cmd_t    cmd;
  lje_status_t status;

  lje_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_op_i    (s_axis_tuser),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .s_ready_o (s_axis_tready),
    .cmd_o     (cmd)
  );

  lje_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .op_i        (s_axis_tuser),
    .pt_i        (s_axis_tdata[15:0]),
    .eta_i       (s_axis_tdata[25:16]),
    .phi_i       (s_axis_tdata[41:26]),
    .btag_i      (s_axis_tdata[42]),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .m_ready_i   (m_axis_tready),
    .status_o    (status),
    .m_data_o    (m_axis_tdata)
  );

  assign m_axis_tvalid = status.out_valid;

endmodule

### hw/rtl/lje_checker.sv
// Port-level checks of the event selector and their binding.
module lje_checker import lje_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [1:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_accept_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[3:1] == RSN_PASS)))
    else $error("accept flag disagrees with reason");

  a_mt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[3:1] == RSN_LEP || m_axis_tdata[3:1] == RSN_JET ||
                      m_axis_tdata[3:1] == RSN_TAG) |-> m_axis_tdata[20:4] == 17'd0)
    else $error("mass reported for an event that failed the counts");

  a_obj_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser != OP_MET && !m_axis_tvalid
    |=> !m_axis_tvalid)
    else $error("result produced by an object beat");

endmodule

bind lepton_jets_event_selector_core lje_checker u_lje_checker (.*);
